>>> rtl/lasm_pkg.sv
// Package for the line-aware substring matcher.
// Holds register codes, fixed field widths and the beat/result structs.
// No dependencies.
package lasm_pkg;

  localparam int CNT_W       = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int PAT_LEN_W   = 5;
  localparam int PAT_BYTES   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 2'd2;

  localparam logic [7:0]       CR_BYTE   = 8'h0D;
  localparam logic [CNT_W-1:0] CNT_SAT   = '1;
  localparam logic [CNT_W-1:0] LINE_INIT = 32'd1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_buffer;
  } lasm_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0] line_number;
    logic [CNT_W-1:0] match_column;
    logic [CNT_W-1:0] match_offset;
  } lasm_result_t;

endpackage

>>> rtl/lasm_cfg.sv
// Configuration registers of the matcher; presents the pattern aligned
// to the byte history (newest byte first) and the clamped length.
// Depends on lasm_pkg.
module lasm_cfg #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int LEN_W             = 5
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_write_en,
  input  logic [lasm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lasm_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic [MAX_PATTERN_BYTES-1:0][7:0]       pat_aligned,
  output logic [LEN_W-1:0]                        pat_len
);
  import lasm_pkg::*;

  logic [CFG_DATA_W-1:0]      pattern_lo_r;
  logic [CFG_DATA_W-1:0]      pattern_hi_r;
  logic [PAT_LEN_W-1:0]       pattern_length_r;
  logic [PAT_BYTES-1:0][7:0]  pat_bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_lo_r     <= '0;
      pattern_hi_r     <= '0;
      pattern_length_r <= PAT_LEN_W'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_PATTERN_LO:  pattern_lo_r     <= cfg_data;
        REG_PATTERN_HI:  pattern_hi_r     <= cfg_data;
        REG_PATTERN_LEN: pattern_length_r <= cfg_data[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = {pattern_hi_r, pattern_lo_r};

  always_comb begin
    if (32'(pattern_length_r) > MAX_PATTERN_BYTES) begin
      pat_len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      pat_len = LEN_W'(pattern_length_r);
    end
  end

  // position k of the history (k = 0 newest) compares with pattern byte len-1-k
  always_comb begin
    int idx;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      idx = int'(pat_len) - 1 - k;
      if (idx >= 0 && idx < PAT_BYTES) begin
        pat_aligned[k] = pat_bytes[idx[3:0]];
      end else begin
        pat_aligned[k] = '0;
      end
    end
  end

endmodule

>>> rtl/lasm_scan.sv
// Line/column/offset counters, byte history and pattern compare.
// Updates state for one beat and forms the match result in the same cycle.
// Depends on lasm_pkg.
module lasm_scan #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int LEN_W             = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  lasm_pkg::lasm_beat_t               beat,
  input  logic [MAX_PATTERN_BYTES-1:0][7:0]  pat_aligned,
  input  logic [LEN_W-1:0]                   pat_len,
  output logic                               hit,
  output lasm_pkg::lasm_result_t             result
);
  import lasm_pkg::*;

  logic [MAX_PATTERN_BYTES-1:0][7:0] recent_r, recent_nxt, recent_sh;
  logic [CNT_W-1:0] line_r, line_nxt;
  logic [CNT_W-1:0] column_r, column_nxt;
  logic [CNT_W-1:0] offset_r, offset_nxt;
  logic             skip_r, skip_nxt;
  logic [CNT_W-1:0] len_m1;
  logic             eq;
  logic             is_cr;

  assign is_cr  = (beat.text_byte == CR_BYTE);
  assign len_m1 = CNT_W'(pat_len) - CNT_W'(1);

  always_comb begin
    recent_sh[0] = beat.text_byte;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      recent_sh[k] = recent_r[k-1];
    end
  end

  always_comb begin
    eq = 1'b1;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      if (32'(k) < 32'(pat_len) && recent_sh[k] != pat_aligned[k]) begin
        eq = 1'b0;
      end
    end
  end

  assign hit = !skip_r && !is_cr && (pat_len != '0) && (column_r >= len_m1) && eq;

  assign result.line_number  = line_r;
  assign result.match_column = (column_r == CNT_SAT) ? CNT_SAT : column_r - len_m1;
  assign result.match_offset = (offset_r == CNT_SAT) ? CNT_SAT : offset_r - len_m1;

  always_comb begin
    recent_nxt = recent_r;
    line_nxt   = line_r;
    column_nxt = column_r;
    offset_nxt = (offset_r == CNT_SAT) ? offset_r : offset_r + CNT_W'(1);
    skip_nxt   = 1'b0;
    priority if (skip_r) begin
      skip_nxt = 1'b0;
    end else if (is_cr) begin
      line_nxt   = (line_r == CNT_SAT) ? line_r : line_r + CNT_W'(1);
      column_nxt = '0;
      skip_nxt   = 1'b1;
    end else begin
      recent_nxt = recent_sh;
      column_nxt = (column_r == CNT_SAT) ? column_r : column_r + CNT_W'(1);
    end
    if (beat.end_of_buffer) begin
      recent_nxt = '0;
      line_nxt   = LINE_INIT;
      column_nxt = '0;
      offset_nxt = '0;
      skip_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      line_r   <= LINE_INIT;
      column_r <= '0;
      offset_r <= '0;
      skip_r   <= 1'b0;
    end else if (fire) begin
      recent_r <= recent_nxt;
      line_r   <= line_nxt;
      column_r <= column_nxt;
      offset_r <= offset_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

>>> rtl/line_aware_substring_matcher_top.sv
// Line-aware substring matcher, top level. Input register, combinational
// compare/count logic, output register. out_valid for a match is set by the
// edge that fires its beat from the input register. Throughput: one byte per cycle,
// limited only by out_stall. Synchronous active-low reset clears counters,
// byte history and pipeline valids; pattern resets to length 1, all zero.
// Depends on lasm_pkg, lasm_cfg, lasm_scan.
module line_aware_substring_matcher_top #(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_text_byte,
  input  logic                                  in_end_of_buffer,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lasm_pkg::CNT_W-1:0]            out_line_number,
  output logic [lasm_pkg::CNT_W-1:0]            out_match_column,
  output logic [lasm_pkg::CNT_W-1:0]            out_match_offset,
  input  logic                                  cfg_write_en,
  input  logic [lasm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lasm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import lasm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

  logic [MAX_PATTERN_BYTES-1:0][7:0] pat_aligned;
  logic [LEN_W-1:0]                  pat_len;
  lasm_beat_t   beat_r;
  logic         beat_vld_r, beat_vld_nxt;
  logic         out_vld_r, out_vld_nxt;
  lasm_result_t res_r, scan_res;
  logic         scan_hit;
  logic         advance, fire, in_take;

  assign advance  = !out_vld_r || !out_stall;
  assign fire     = beat_vld_r && advance;
  assign in_stall = beat_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  lasm_cfg #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .LEN_W(LEN_W)
  ) u_cfg (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pat_aligned(pat_aligned),
    .pat_len(pat_len)
  );

  lasm_scan #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .LEN_W(LEN_W)
  ) u_scan (
    .clk(clk),
    .rst_n(rst_n),
    .fire(fire),
    .beat(beat_r),
    .pat_aligned(pat_aligned),
    .pat_len(pat_len),
    .hit(scan_hit),
    .result(scan_res)
  );

  assign beat_vld_nxt = in_take || (beat_vld_r && !advance);

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = scan_hit;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      beat_vld_r <= beat_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      beat_r.text_byte     <= in_text_byte;
      beat_r.end_of_buffer <= in_end_of_buffer;
    end
    if (fire && scan_hit) begin
      res_r <= scan_res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_line_number  = res_r.line_number;
  assign out_match_column = res_r.match_column;
  assign out_match_offset = res_r.match_offset;

endmodule

>>> test/tb_line_aware_substring_matcher_top.sv
`timescale 1ns / 100ps
// Testbench for line_aware_substring_matcher_top: directed and random text beats,
// each match checked in order against an in-bench line/column/offset predictor.
// Depends on lasm_pkg and the matcher RTL.
module tb_line_aware_substring_matcher_top;
  import lasm_pkg::*;

  localparam int LATENCY_WAIT = 8;
  localparam int PHASE_BEATS  = 75;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_text_byte;
  logic                  in_end_of_buffer;
  logic                  out_valid;
  logic                  out_stall;
  logic [CNT_W-1:0]      out_line_number;
  logic [CNT_W-1:0]      out_match_column;
  logic [CNT_W-1:0]      out_match_offset;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of registers and line state
  logic [127:0]          pattern_bits;
  logic [PAT_LEN_W-1:0]  pattern_len;
  logic [7:0]            line_bytes [PAT_BYTES];
  logic [CNT_W-1:0]      cur_line;
  logic [CNT_W-1:0]      cur_col;
  logic [CNT_W-1:0]      cur_offset;
  logic                  drop_next;
  lasm_result_t          expected_matches [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_req    = 0;
  int fail_count     = 0;
  int beats_sent     = 0;
  int phase_count    = 0;
  int len_choices [15] = '{1, 16, 0, 31, 2, 3, 17, 4, 5, 8, 12, 6, 20, 16, 1};

  line_aware_substring_matcher_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_number  (out_line_number),
    .out_match_column (out_match_column),
    .out_match_offset (out_match_offset),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_SAT) ? v : v + 1'b1;
  endfunction

  function automatic logic [7:0] ab_byte();
    return ($urandom_range(1) != 0) ? 8'h61 : 8'h62;
  endfunction

  function automatic void clear_line_state();
    foreach (line_bytes[k]) line_bytes[k] = 8'h00;
    cur_line   = LINE_INIT;
    cur_col    = '0;
    cur_offset = '0;
    drop_next  = 1'b0;
  endfunction

  function automatic void predict_match(input logic [7:0] b, input logic eob);
    int           eff_len;
    bit           hit;
    lasm_result_t r;
    if (drop_next) begin
      drop_next  = 1'b0;
      cur_offset = sat_inc(cur_offset);
    end else if (b == CR_BYTE) begin
      cur_line   = sat_inc(cur_line);
      cur_col    = '0;
      drop_next  = 1'b1;
      cur_offset = sat_inc(cur_offset);
    end else begin
      eff_len = (pattern_len > PAT_BYTES) ? PAT_BYTES : int'(pattern_len);
      for (int k = PAT_BYTES - 1; k > 0; k--) line_bytes[k] = line_bytes[k-1];
      line_bytes[0] = b;
      if (eff_len > 0 && cur_col >= eff_len - 1) begin
        hit = 1'b1;
        for (int k = 0; k < eff_len; k++) begin
          if (line_bytes[k] != pattern_bits[8*(eff_len-1-k) +: 8]) hit = 1'b0;
        end
        if (hit) begin
          r.line_number  = cur_line;
          r.match_column = (cur_col == CNT_SAT) ? CNT_SAT : cur_col - (eff_len - 1);
          r.match_offset = (cur_offset == CNT_SAT) ? CNT_SAT : cur_offset - (eff_len - 1);
          expected_matches.push_back(r);
        end
      end
      cur_col    = sat_inc(cur_col);
      cur_offset = sat_inc(cur_offset);
    end
    if (eob) clear_line_state();
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LO:  pattern_bits[63:0]   = data;
      REG_PATTERN_HI:  pattern_bits[127:64] = data;
      REG_PATTERN_LEN: pattern_len          = data[PAT_LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [PAT_LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[PAT_LEN_W-1:0] = len;
    write_reg(REG_PATTERN_LO, lo);
    write_reg(REG_PATTERN_HI, hi);
    write_reg(REG_PATTERN_LEN, len_word);
    cfg_write_en <= 1'b0;
  endtask

  task automatic send_beat(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_text_byte     <= b;
    in_end_of_buffer <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_match(b, eob);
    beats_sent++;
  endtask

  task automatic send_text(input logic [7:0] b);
    send_beat(b, $urandom_range(59) == 0);
  endtask

  task automatic drain_matches();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  // reset pattern: single zero byte
  task automatic test_default_pattern();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(CR_BYTE, 1'b0);
    send_beat(CR_BYTE, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b1);
    drain_matches();
  endtask

  task automatic test_long_pattern();
    load_pattern(64'h3736_3534_3332_00FF, 64'h4746_4544_4342_4140, PAT_LEN_W'(16));
    for (int k = 0; k < PAT_BYTES; k++) begin
      send_beat(pattern_bits[8*k +: 8], k == PAT_BYTES - 1);
    end
    drain_matches();
  endtask

  task automatic test_zero_length();
    load_pattern(64'h0, 64'h0, PAT_LEN_W'(0));
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b1);
    drain_matches();
  endtask

  task automatic test_random_text(input int s_pct, input int r_pct);
    logic [63:0] lo;
    logic [63:0] hi;
    int          len;
    int          eff_len;
    int          start;
    int          pick;
    int          seg;
    int          r;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    for (int ph = 0; ph < 5; ph++) begin
      len = len_choices[phase_count % 15];
      if (phase_count % 2 != 0) begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end else begin
        for (int i = 0; i < 8; i++) begin
          lo[8*i +: 8] = ab_byte();
          hi[8*i +: 8] = ab_byte();
        end
      end
      phase_count++;
      load_pattern(lo, hi, PAT_LEN_W'(len));
      eff_len = (len > PAT_BYTES) ? PAT_BYTES : len;
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          // whole pattern copy, or a truncated one
          if (eff_len == 0) seg = $urandom_range(1, 3);
          else if (pick < 38) seg = eff_len;
          else seg = $urandom_range(eff_len);
          for (int k = 0; k < seg; k++) begin
            send_text((eff_len == 0) ? ab_byte() : pattern_bits[8*k +: 8]);
          end
        end else if (pick < 85) begin
          r = $urandom_range(9);
          if (r < 5 && eff_len > 0)
            send_text(pattern_bits[8*$urandom_range(eff_len - 1) +: 8]);
          else if (r < 8)
            send_text(ab_byte());
          else
            send_text(8'($urandom_range(255)));
        end else begin
          send_text(CR_BYTE);
          r = $urandom_range(19);
          if (r < 14) send_text(8'h0A);
          else if (r < 17) send_text(CR_BYTE);
          else send_text(8'($urandom_range(255)));
        end
      end
      drain_matches();
    end
  endtask

  // output held off long enough to back up into the input
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_pattern(64'h6161, 64'h0, PAT_LEN_W'(2));
    holdoff_req = 300;
    for (int k = 0; k < 150; k++) send_beat(8'h61, 1'b0);
    send_beat(8'h61, 1'b1);
    drain_matches();
  endtask

  // result sink: random stalls plus requested hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req > 0) begin
        hold_left   = holdoff_req;
        holdoff_req = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    lasm_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_matches.size() == 0) begin
          $error("unexpected match beat: line %0d column %0d offset %0d",
                 out_line_number, out_match_column, out_match_offset);
          fail_count++;
        end else begin
          want = expected_matches.pop_front();
          if (out_line_number !== want.line_number) begin
            $error("line_number: expected %0d, got %0d", want.line_number, out_line_number);
            fail_count++;
          end
          if (out_match_column !== want.match_column) begin
            $error("match_column: expected %0d, got %0d", want.match_column, out_match_column);
            fail_count++;
          end
          if (out_match_offset !== want.match_offset) begin
            $error("match_offset: expected %0d, got %0d", want.match_offset, out_match_offset);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("line_aware_substring_matcher_top: mismatch");
    $finish;
  end

  initial begin
    in_valid         = 1'b0;
    in_text_byte     = 8'h00;
    in_end_of_buffer = 1'b0;
    cfg_write_en     = 1'b0;
    cfg_index        = REG_PATTERN_LO;
    cfg_data         = '0;
    rst_n            = 1'b0;
    pattern_bits     = '0;
    pattern_len      = PAT_LEN_W'(1);
    clear_line_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_pattern();
    test_long_pattern();
    test_zero_length();
    test_random_text(7, 77);
    test_random_text(77, 7);
    test_random_text(0, 0);
    test_output_holdoff();

    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && expected_matches.size() != 0; i++) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
    if (expected_matches.size() != 0) begin
      $error("%0d expected match beats never arrived", expected_matches.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("line_aware_substring_matcher_top: match");
    end else begin
      $display("line_aware_substring_matcher_top: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lasm_pkg.sv
rtl/lasm_cfg.sv
rtl/lasm_scan.sv
rtl/line_aware_substring_matcher_top.sv
test/tb_line_aware_substring_matcher_top.sv
